>>> design/grd_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and defaults for the grid ray traversal block.
package grd_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_MAX_ROWS  = 16;
    localparam int DEF_MAX_COLS  = 16;
    localparam int DEF_CELL_BITS = 8;

    // Fixed-point format of all positions, directions and distances
    localparam int FRAC_BITS = 16;

    localparam int REG_W   = 5;     // map_rows / map_cols register width
    localparam int POS_W   = 20;    // start_x / start_y
    localparam int DIR_W   = 19;    // dir_x / dir_y
    localparam int MAG_W   = 19;    // |dir|, at most 2^18
    localparam int QUO_W   = 33;    // side and delta quotients, at most 2^32
    localparam int SIDE_W  = 48;    // accumulated side distances and t
    localparam int PROD_W  = SIDE_W + MAG_W;
    localparam int COORD_W = 8;     // signed cell coordinate, -1 .. MAX_ROWS / MAX_COLS
    localparam int CODE_W  = 8;     // cell_code field
    localparam int IDX_W   = 4;     // cell_row / cell_col fields
    localparam int FC_W    = 9;     // final_cell field
    localparam int DIST_W  = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One classified item on its way from the front to the back
    typedef struct packed {
        logic              is_cast;
        logic [IDX_W-1:0]  cell_row;
        logic [IDX_W-1:0]  cell_col;
        logic [CODE_W-1:0] cell_code;
        logic [POS_W-1:0]  start_x;
        logic [POS_W-1:0]  start_y;
        logic [MAG_W-1:0]  mag_x;
        logic [MAG_W-1:0]  mag_y;
        logic              neg_x;
        logic              neg_y;
    } grd_item_t;

    // One cast result
    typedef struct packed {
        logic [FC_W-1:0]   final_cell;
        logic              vertical_side;
        logic              hit;
        logic [31:0]       hit_y;
        logic [31:0]       hit_x;
        logic [DIST_W-1:0] distance;
    } grd_result_t;

endpackage

>>> design/grd_front.sv
`timescale 1ns / 1ps
// Front end: accepts stream transactions, splits direction into sign and magnitude.
module grd_front
    import grd_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [95:0] s_tdata,
    input  logic       s_tuser,
    input  logic       clearing,
    input  logic       q_full,
    output logic       q_push,
    output grd_item_t  q_item
);

    logic              accept;
    logic              in_range;
    logic [DIR_W-1:0]  dir_x;
    logic [DIR_W-1:0]  dir_y;

    // Hold off new transactions during reset, while the map store is being cleared or the queue is full
    assign s_tready = !clearing && !q_full && rst_n;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        dir_x = s_tdata[74:56];
        dir_y = s_tdata[93:75];

        q_item.is_cast   = s_tuser;
        q_item.cell_row  = s_tdata[3:0];
        q_item.cell_col  = s_tdata[7:4];
        q_item.cell_code = s_tdata[15:8];
        q_item.start_x   = s_tdata[35:16];
        q_item.start_y   = s_tdata[55:36];
        q_item.neg_x     = dir_x[DIR_W-1];
        q_item.neg_y     = dir_y[DIR_W-1];
        q_item.mag_x     = dir_x[DIR_W-1] ? MAG_W'(~dir_x + DIR_W'(1)) : dir_x;
        q_item.mag_y     = dir_y[DIR_W-1] ? MAG_W'(~dir_y + DIR_W'(1)) : dir_y;

        in_range = (COORD_W'(s_tdata[3:0]) < COORD_W'(MAX_ROWS))
                && (COORD_W'(s_tdata[7:4]) < COORD_W'(MAX_COLS));
    end

    // Drop cell writes that fall outside the store
    assign q_push = accept && (s_tuser || in_range);

endmodule

>>> design/grd_queue.sv
`timescale 1ns / 1ps
// Short queue of classified items between front and back.
module grd_queue
    import grd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  grd_item_t push_item,
    input  logic      pop,
    output logic      full,
    output logic      empty,
    output grd_item_t head
);

    grd_item_t           entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

>>> design/grd_back.sv
`timescale 1ns / 1ps
// Back end: map store, reciprocal dividers, DDA stepper, hit-point multiplier, output stage.
module grd_back
    import grd_pkg::*;
#(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int CELL_BITS = DEF_CELL_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [REG_W-1:0] map_rows,
    input  logic [REG_W-1:0] map_cols,
    input  logic             q_empty,
    input  grd_item_t        q_item,
    output logic             q_pop,
    output logic             clearing,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [111:0]     m_tdata,
    output logic             m_tuser
);

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LANES  = 4;
    localparam int CNT_W  = 6;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_TEST  = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    function automatic logic in_area(input logic signed [COORD_W-1:0] r,
                                     input logic signed [COORD_W-1:0] c,
                                     input logic signed [COORD_W-1:0] nr,
                                     input logic signed [COORD_W-1:0] nc);
        return (r >= 0) && (r < nr) && (c >= 0) && (c < nc);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                    input logic [COORD_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_COLS + int'(c));
    endfunction

    function automatic logic [31:0] hit_point(input logic [POS_W-1:0]  start,
                                              input logic [PROD_W-1:0] prod,
                                              input logic              neg);
        logic [PROD_W-FRAC_BITS-1:0] p;
        logic [32:0]                 pc;
        logic signed [34:0]          v;
        p  = prod[PROD_W-1:FRAC_BITS];
        pc = (|p[PROD_W-FRAC_BITS-1:32]) ? 33'h1_0000_0000 : {1'b0, p[31:0]};
        v  = neg ? $signed({15'b0, start}) - $signed({2'b0, pc})
                 : $signed({15'b0, start}) + $signed({2'b0, pc});
        if (v > 35'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        else if (v < -35'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    logic [2:0]              state_reg;
    logic [ADDR_W-1:0]       clr_cnt_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    out_valid_reg;
    grd_result_t             out_reg;

    logic [CELL_BITS-1:0]    mem [CELLS];
    logic [CELL_BITS-1:0]    cell_q_reg;

    logic [POS_W-1:0]        sx_reg;
    logic [POS_W-1:0]        sy_reg;
    logic [MAG_W-1:0]        mx_reg;
    logic [MAG_W-1:0]        my_reg;
    logic                    nx_reg;
    logic                    ny_reg;
    logic signed [COORD_W-1:0] row_reg;
    logic signed [COORD_W-1:0] col_reg;

    logic [QUO_W-1:0]        num_reg  [LANES];
    logic [MAG_W-1:0]        rem_reg  [LANES];
    logic [QUO_W-1:0]        quo_reg  [LANES];
    logic [QUO_W-1:0]        num_next [LANES];
    logic [MAG_W-1:0]        rem_next [LANES];
    logic [QUO_W-1:0]        quo_next [LANES];
    logic [MAG_W:0]          trial    [LANES];
    logic [MAG_W-1:0]        dvs      [LANES];

    logic [SIDE_W-1:0]       side_x_reg;
    logic [SIDE_W-1:0]       side_y_reg;
    logic [SIDE_W-1:0]       t_reg;
    logic                    vert_reg;
    logic                    hit_reg;
    logic [FC_W-1:0]         fc_reg;
    logic [PROD_W-1:0]       acc_x_reg;
    logic [PROD_W-1:0]       acc_y_reg;
    logic [MAG_W-1:0]        mlx_reg;
    logic [MAG_W-1:0]        mly_reg;

    logic signed [COORD_W-1:0] eff_rows;
    logic signed [COORD_W-1:0] eff_cols;
    logic signed [COORD_W-1:0] item_row;
    logic signed [COORD_W-1:0] item_col;
    logic signed [COORD_W-1:0] new_row;
    logic signed [COORD_W-1:0] new_col;
    logic                    item_in;
    logic                    cur_in;
    logic                    new_in;
    logic                    step_x;
    logic                    hit_found;
    logic [FC_W-1:0]         cur_code;
    logic [FRAC_BITS:0]      init_x;
    logic [FRAC_BITS:0]      init_y;

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [CELL_BITS-1:0]    wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    grd_result_t             res;

    assign clearing = (state_reg == S_CLEAR);
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    always_comb
    begin
        eff_rows = (COORD_W'(map_rows) > COORD_W'(MAX_ROWS)) ? COORD_W'(MAX_ROWS)
                                                             : COORD_W'(map_rows);
        eff_cols = (COORD_W'(map_cols) > COORD_W'(MAX_COLS)) ? COORD_W'(MAX_COLS)
                                                             : COORD_W'(map_cols);
        item_row = COORD_W'(q_item.start_y[POS_W-1:FRAC_BITS]);
        item_col = COORD_W'(q_item.start_x[POS_W-1:FRAC_BITS]);
        item_in  = in_area(item_row, item_col, eff_rows, eff_cols);
        cur_in   = in_area(row_reg, col_reg, eff_rows, eff_cols);

        // Nearer grid line wins; ties go to the horizontal line
        step_x  = (mx_reg != '0) && ((my_reg == '0) || (side_x_reg < side_y_reg));
        new_row = row_reg;
        new_col = col_reg;
        if (step_x)
        begin
            new_col = nx_reg ? col_reg - COORD_W'(1) : col_reg + COORD_W'(1);
        end
        else
        begin
            new_row = ny_reg ? row_reg - COORD_W'(1) : row_reg + COORD_W'(1);
        end
        new_in    = in_area(new_row, new_col, eff_rows, eff_cols);
        hit_found = cur_in && (cell_q_reg != '0);
        cur_code  = cur_in ? FC_W'({{FC_W{1'b0}}, cell_q_reg}) : '1;

        // Distance to the first grid line, in units of 2^-FRAC_BITS
        init_x = q_item.neg_x ? {1'b0, q_item.start_x[FRAC_BITS-1:0]}
                              : (FRAC_BITS+1)'(1 << FRAC_BITS)
                                - {1'b0, q_item.start_x[FRAC_BITS-1:0]};
        init_y = q_item.neg_y ? {1'b0, q_item.start_y[FRAC_BITS-1:0]}
                              : (FRAC_BITS+1)'(1 << FRAC_BITS)
                                - {1'b0, q_item.start_y[FRAC_BITS-1:0]};

        // Restoring division, one quotient bit per lane per cycle
        dvs[0] = mx_reg;
        dvs[1] = mx_reg;
        dvs[2] = my_reg;
        dvs[3] = my_reg;
        for (int i = 0; i < LANES; i++)
        begin
            trial[i] = {rem_reg[i], num_reg[i][QUO_W-1]};
            if (trial[i] >= {1'b0, dvs[i]})
            begin
                rem_next[i] = MAG_W'(trial[i] - {1'b0, dvs[i]});
                quo_next[i] = {quo_reg[i][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[i][MAG_W-1:0];
                quo_next[i] = {quo_reg[i][QUO_W-2:0], 1'b0};
            end
            num_next[i] = {num_reg[i][QUO_W-2:0], 1'b0};
        end

        // Map store port control
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = cell_addr(item_row, item_col);
        if (state_reg == S_CLEAR)
        begin
            wr_en = 1'b1;
        end
        else if (q_pop && !q_item.is_cast)
        begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(COORD_W'(q_item.cell_row), COORD_W'(q_item.cell_col));
            wr_data = CELL_BITS'({16'b0, q_item.cell_code});
        end
        if (q_pop && q_item.is_cast)
        begin
            rd_en = item_in;
        end
        else if (state_reg == S_STEP)
        begin
            rd_en   = new_in;
            rd_addr = cell_addr(new_row, new_col);
        end

        res.distance      = !hit_reg ? '1
                          : (t_reg > SIDE_W'(32'hFFFF_FFFE)) ? 32'hFFFF_FFFE
                          : t_reg[DIST_W-1:0];
        res.hit_x         = hit_point(sx_reg, acc_x_reg, nx_reg);
        res.hit_y         = hit_point(sy_reg, acc_y_reg, ny_reg);
        res.hit           = hit_reg;
        res.vertical_side = vert_reg;
        res.final_cell    = fc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            cell_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A result loaded in S_DONE takes over the output register instead
            if (out_valid_reg && m_tready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(CELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_pop && q_item.is_cast)
                    begin
                        sx_reg   <= q_item.start_x;
                        sy_reg   <= q_item.start_y;
                        mx_reg   <= q_item.mag_x;
                        my_reg   <= q_item.mag_y;
                        nx_reg   <= q_item.neg_x;
                        ny_reg   <= q_item.neg_y;
                        row_reg  <= item_row;
                        col_reg  <= item_col;
                        t_reg    <= '0;
                        vert_reg <= 1'b0;
                        hit_reg  <= 1'b0;
                        num_reg[0] <= {init_x, FRAC_BITS'(0)};
                        num_reg[1] <= QUO_W'(64'd1 << (2 * FRAC_BITS));
                        num_reg[2] <= {init_y, FRAC_BITS'(0)};
                        num_reg[3] <= QUO_W'(64'd1 << (2 * FRAC_BITS));
                        for (int i = 0; i < LANES; i++)
                        begin
                            rem_reg[i] <= '0;
                            quo_reg[i] <= '0;
                        end
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        num_reg[i] <= num_next[i];
                        rem_reg[i] <= rem_next[i];
                        quo_reg[i] <= quo_next[i];
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(QUO_W - 1))
                    begin
                        side_x_reg <= SIDE_W'(quo_next[0]);
                        side_y_reg <= SIDE_W'(quo_next[2]);
                        if (((mx_reg == '0) && (my_reg == '0)) || !cur_in)
                        begin
                            // Immediate miss: report the start cell's code, or all ones if it lies outside the map
                            fc_reg    <= cur_code;
                            acc_x_reg <= '0;
                            acc_y_reg <= '0;
                            mlx_reg   <= mx_reg;
                            mly_reg   <= my_reg;
                            cnt_reg   <= '0;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            state_reg <= S_STEP;
                        end
                    end
                end
                S_STEP:
                begin
                    row_reg <= new_row;
                    col_reg <= new_col;
                    if (step_x)
                    begin
                        t_reg      <= side_x_reg;
                        side_x_reg <= side_x_reg + SIDE_W'(quo_reg[1]);
                        vert_reg   <= 1'b1;
                    end
                    else
                    begin
                        t_reg      <= side_y_reg;
                        side_y_reg <= side_y_reg + SIDE_W'(quo_reg[3]);
                        vert_reg   <= 1'b0;
                    end
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (hit_found || !cur_in)
                    begin
                        hit_reg   <= hit_found;
                        fc_reg    <= cur_code;
                        acc_x_reg <= '0;
                        acc_y_reg <= '0;
                        mlx_reg   <= mx_reg;
                        mly_reg   <= my_reg;
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_MUL:
                begin
                    // Shift-add t * |dir|, multiplier MSB first
                    acc_x_reg <= {acc_x_reg[PROD_W-2:0], 1'b0}
                               + (mlx_reg[MAG_W-1] ? PROD_W'(t_reg) : '0);
                    acc_y_reg <= {acc_y_reg[PROD_W-2:0], 1'b0}
                               + (mly_reg[MAG_W-1] ? PROD_W'(t_reg) : '0);
                    mlx_reg   <= {mlx_reg[MAG_W-2:0], 1'b0};
                    mly_reg   <= {mly_reg[MAG_W-2:0], 1'b0};
                    cnt_reg   <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(MAG_W - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_reg       <= res;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.hit;
    assign m_tdata  = {6'b0, out_reg.final_cell, out_reg.vertical_side, out_reg.hit_y,
                       out_reg.hit_x, out_reg.distance};

endmodule

>>> design/grid_ray_dda_traversal.sv
`timescale 1ns / 1ps
// Top level of the grid ray traversal block: config registers, front, queue, back.
//
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    s_tuser mode, s_tdata cell write or ray
//  m_*       out        m_tvalid / m_tready    m_tuser hit, m_tdata result fields
//  apb       in         psel & penable         map_rows at 0x0, map_cols at 0x4
//
// A cell write goes to the map store as it leaves the queue. A ray runs a 33-bit
// radix-2 division, then one S_STEP / S_TEST pair per grid line crossed (at most
// rows + columns) for the map store read, then a 19-bit shift-add hit point.
// After reset the map store is cleared one cell a cycle, all MAX_ROWS*MAX_COLS cells,
// with s_tready low. A two-entry queue and an output register decouple both sides.
module grid_ray_dda_traversal
    import grd_pkg::*;
#(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int CELL_BITS = DEF_CELL_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cell_row, cell_col, cell_code, start_x, start_y, dir_x, dir_y, zero fill
    input  logic [95:0]  s_tdata,
    // mode
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance, hit_x, hit_y, vertical_side, final_cell, zero fill
    output logic [111:0] m_tdata,
    // hit
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    logic [REG_W-1:0] map_rows_reg;
    logic [REG_W-1:0] map_cols_reg;
    logic             cfg_write;
    logic             clearing;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    grd_item_t        push_item;
    grd_item_t        head_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_COLS) ? 32'(map_cols_reg) : 32'(map_rows_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_rows_reg <= REG_W'(16);
            map_cols_reg <= REG_W'(16);
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_ROWS)
            begin
                map_rows_reg <= pwdata[REG_W-1:0];
            end
            else
            begin
                map_cols_reg <= pwdata[REG_W-1:0];
            end
        end
    end

    grd_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    grd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head_item)
    );

    grd_back #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .CELL_BITS (CELL_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .map_rows (map_rows_reg),
        .map_cols (map_cols_reg),
        .q_empty  (q_empty),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> design/grd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the grid ray traversal block, bound to the top level.
module grd_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic         m_tuser
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Hit flag and the all-ones miss distance agree
    a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == (m_tdata[31:0] != 32'hFFFF_FFFF)))
        else $error("hit flag and distance disagree");

    // No result is offered during reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

endmodule

bind grid_ray_dda_traversal grd_checker u_grd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
